### design/tad_pkg.sv
package tad_pkg;

  localparam int SAMPLE_BITS  = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int FRAC_SHIFT   = 8;

  // Sum of squares, the radicand after fraction scaling and the root.
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int RAD_W  = SQ_W + 2 * FRAC_SHIFT;
  localparam int ROOT_W = SAMPLE_BITS + FRAC_SHIFT;

  // CORDIC x/y path: the vector length grows by the CORDIC gain of about 1.65.
  localparam int CW = ROOT_W + 3;

  // Angle accumulator in units of 1e-8 degree; its range is set by the table.
  localparam int ACC_W = 36;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 36'sd9000000000;
  localparam logic signed [ACC_W-1:0] ROUND_HALF   = 36'sd500000;

  localparam logic signed [ACC_W-1:0] ATAN_UNITS [TABLE_LEN] = '{
    36'sd4500000000, 36'sd2656505118, 36'sd1403624347, 36'sd712501635,
    36'sd357633437,  36'sd178991061,  36'sd89517371,   36'sd44761417,
    36'sd22381050,   36'sd11190568,   36'sd5595289,    36'sd2797645,
    36'sd1398823,    36'sd699411,     36'sd349706,     36'sd174853,
    36'sd87426,      36'sd43713,      36'sd21857,      36'sd10928,
    36'sd5464,       36'sd2732,       36'sd1366,       36'sd683
  };

  // Output scaling: divide by 1e6 as a shift by 6 and a division by 15625,
  // the latter done by multiplying with a rounded-up reciprocal.
  localparam int CENTI_W     = 15;
  localparam int DIV_SHIFT   = 6;
  localparam int B_W         = ACC_W - 1 - DIV_SHIFT;
  localparam int RECIP_SHIFT = B_W + 14;
  localparam int RECIP_W     = 30;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'd15624) / 64'd15625;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  localparam logic [CENTI_W-1:0] MAX_CENTIDEG = 15'd18000;
  // Rounded sums at or above this give more than 18000 and saturate.
  localparam logic [ACC_W-2:0]   SAT_LIMIT    = 35'd18001000000;
  localparam logic [CENTI_W-1:0] THRESH_RESET = 15'd4500;

endpackage

### design/tilt_angle_detector.sv
// Channel     Handshake        Payload
// ----------  ---------------  --------------------------------------------
// sample in   start / busy     accel_x, accel_y, accel_z (signed)
// result out  done (strobe)    tilt_centideg, tipped
// config      cfg_write        cfg_data (tilt threshold, centidegrees)
//
// A request is taken at every edge with start high; busy is always low, so a
// sample may be issued in every cycle. The result is registered through one
// stage per square-root bit and one per CORDIC iteration, plus squaring,
// summing, pre-rotation and four output scaling stages.
// Synchronous reset clears the valid bits and sets the threshold to 45 degrees.
// The receiver cannot stall.
module tilt_angle_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [tad_pkg::SAMPLE_BITS-1:0] accel_x,
  input  logic signed [tad_pkg::SAMPLE_BITS-1:0] accel_y,
  input  logic signed [tad_pkg::SAMPLE_BITS-1:0] accel_z,
  input  logic                                   cfg_write,
  input  logic [tad_pkg::CENTI_W-1:0]            cfg_data,
  output logic                                   done,
  output logic [tad_pkg::CENTI_W-1:0]            tilt_centideg,
  output logic                                   tipped
);
  import tad_pkg::*;

  logic [CENTI_W-1:0] threshold;

  // Squaring stage.
  logic                     sq_valid;
  logic signed [SQ_W-1:0]   sq_x;
  logic signed [SQ_W-1:0]   sq_y;
  logic signed [SAMPLE_BITS-1:0] sq_z;

  // Summing stage.
  logic                     sum_valid;
  logic [SQ_W-1:0]          sum_sq;
  logic signed [SAMPLE_BITS-1:0] sum_z;

  // Square-root stages, one result bit each.
  logic                          rt_valid [ROOT_W+1];
  logic [RAD_W-1:0]              rt_rem   [ROOT_W+1];
  logic [ROOT_W-1:0]             rt_root  [ROOT_W+1];
  logic signed [SAMPLE_BITS-1:0] rt_z     [ROOT_W+1];

  // CORDIC stages, index 0 is the pre-rotated vector.
  logic                    cd_valid [CORDIC_STEPS+1];
  logic signed [CW-1:0]    cd_x     [CORDIC_STEPS+1];
  logic signed [CW-1:0]    cd_y     [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] cd_acc   [CORDIC_STEPS+1];

  // Output scaling stages.
  logic                    f1_valid, f2_valid, f3_valid;
  logic                    f1_pos, f2_pos, f3_pos;
  logic                    f2_sat, f3_sat;
  logic signed [ACC_W-1:0] f1_sum;
  logic [B_W-1:0]          f2_b;
  logic [CENTI_W-1:0]      f3_q;

  logic signed [CW-1:0]         zs;
  logic signed [CW-1:0]         h_ext;
  logic [B_W+RECIP_W-1:0]       prod;
  logic [CENTI_W-1:0]           centi_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      sq_valid  <= start;
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_x   <= accel_x * accel_x;
    sq_y   <= accel_y * accel_y;
    sq_z   <= accel_z;
    sum_sq <= $unsigned(sq_x) + $unsigned(sq_y);
    sum_z  <= sq_z;
  end

  assign rt_valid[0] = sum_valid;
  assign rt_rem[0]   = {sum_sq, {(2*FRAC_SHIFT){1'b0}}};
  assign rt_root[0]  = '0;
  assign rt_z[0]     = sum_z;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - i;
    logic [RAD_W:0] trial;
    logic           take;

    // With rem = n - root^2, setting bit K of the root costs root*2^(K+1) + 4^K.
    assign trial = ((RAD_W+1)'(rt_root[i]) << (K + 1)) | ((RAD_W+1)'(1) << (2 * K));
    assign take  = {1'b0, rt_rem[i]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_valid[i+1] <= 1'b0;
      end else begin
        rt_valid[i+1] <= rt_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      rt_rem[i+1]  <= take ? rt_rem[i] - trial[RAD_W-1:0] : rt_rem[i];
      rt_root[i+1] <= take ? rt_root[i] | (ROOT_W'(1) << K) : rt_root[i];
      rt_z[i+1]    <= rt_z[i];
    end
  end

  assign zs    = CW'(rt_z[ROOT_W]) <<< FRAC_SHIFT;
  assign h_ext = $signed(CW'(rt_root[ROOT_W]));

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_valid[0] <= 1'b0;
    end else begin
      cd_valid[0] <= rt_valid[ROOT_W];
    end
  end

  // A vector below the horizontal is turned by a quarter turn first.
  always_ff @(posedge clk) begin
    if (zs >= 0) begin
      cd_x[0]   <= zs;
      cd_y[0]   <= h_ext;
      cd_acc[0] <= '0;
    end else begin
      cd_x[0]   <= h_ext;
      cd_y[0]   <= -zs;
      cd_acc[0] <= QUARTER_TURN;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 up;

    assign dx = cd_y[i] >>> i;
    assign dy = cd_x[i] >>> i;
    assign up = cd_y[i] > 0;

    always_ff @(posedge clk) begin
      if (rst) begin
        cd_valid[i+1] <= 1'b0;
      end else begin
        cd_valid[i+1] <= cd_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (up) begin
        cd_x[i+1]   <= cd_x[i] + dx;
        cd_y[i+1]   <= cd_y[i] - dy;
        cd_acc[i+1] <= cd_acc[i] + ATAN_UNITS[i];
      end else begin
        cd_x[i+1]   <= cd_x[i] - dx;
        cd_y[i+1]   <= cd_y[i] + dy;
        cd_acc[i+1] <= cd_acc[i] - ATAN_UNITS[i];
      end
    end
  end

  // The reciprocal is exact for every shifted sum below 2^B_W.
  assign prod = f2_b * RECIP;

  always_comb begin
    if (!f3_pos) begin
      centi_next = '0;
    end else if (f3_sat) begin
      centi_next = MAX_CENTIDEG;
    end else begin
      centi_next = f3_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      f1_valid <= cd_valid[CORDIC_STEPS];
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      done     <= f3_valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_sum        <= cd_acc[CORDIC_STEPS] + ROUND_HALF;
    f1_pos        <= cd_acc[CORDIC_STEPS] > 0;
    f2_pos        <= f1_pos;
    f2_sat        <= f1_sum[ACC_W-2:0] >= SAT_LIMIT;
    f2_b          <= f1_sum[ACC_W-2:DIV_SHIFT];
    f3_pos        <= f2_pos;
    f3_sat        <= f2_sat;
    f3_q          <= prod[RECIP_SHIFT +: CENTI_W];
    tilt_centideg <= centi_next;
    tipped        <= centi_next > threshold;
  end

endmodule
